// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the timer queue RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define EDTQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define EDTQ_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ===== rtl/edtq_pkg.sv =====
// Shared types and constants of the earliest-deadline timer queue.
// Depends on nothing; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package edtq_pkg;

   // Table geometry
   localparam int SLOTS        = 16;
   localparam int ID_BITS      = 4;
   localparam int TIME_BITS    = 48;
   localparam int ORDER_BITS   = 16;
   localparam int INDEX_BITS   = $clog2(SLOTS);
   localparam int RESULT_LIMIT = 16;
   localparam int COUNT_BITS   = $clog2(RESULT_LIMIT + 1);

   localparam logic [ORDER_BITS-1:0] ORDER_TOP = '1;
   localparam logic [TIME_BITS-1:0]  TIME_NONE = '1;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_ARM    = 2'd0,
      OP_CANCEL = 2'd1,
      OP_TICK   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_COMPACT,
      ST_APPLY,
      ST_WRITE,
      ST_SEARCH,
      ST_CHECK
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic arm_write;
      logic disarm;
      logic rank_clear;
      logic rank_step;
      logic rank_apply;
      logic scan_clear;
      logic scan_step;
      logic load_earliest;
      logic expire;
      logic emit;
      logic emit_valid;
      logic emit_status;
      logic emit_last;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      op_type op;
      logic   id_in_range;
      logic   id_armed;
      logic   order_top;
      logic   idx_last;
      logic   pending;
      logic   due;
      logic   count_full;
   } dp_status_type;

endpackage

// ===== rtl/edtq_datapath.sv =====
// Datapath of the timer queue: slot registers, search unit, order compaction, result register.
// Depends on edtq_pkg; driven by commands from edtq_ctrl.
`timescale 1ns / 1ps

module edtq_datapath
   import edtq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_operation,
   input  logic [ID_BITS-1:0]    req_timer_id,
   input  logic [TIME_BITS-1:0]  req_expire_time,
   input  logic [TIME_BITS-1:0]  req_now_time,
   input  cmd_type               cmd,
   output dp_status_type         status,
   output logic                  rsp_strobe,
   output logic                  rsp_expired_valid,
   output logic [ID_BITS-1:0]    rsp_expired_id,
   output logic [TIME_BITS-1:0]  rsp_next_expire,
   output logic                  rsp_status,
   output logic                  rsp_last
);

`include "assert_macros.svh"

   // Latched request
   op_type                  req_op_ff;
   logic [ID_BITS-1:0]      req_id_ff;
   logic [TIME_BITS-1:0]    req_expire_ff;
   logic [TIME_BITS-1:0]    req_now_ff;

   // Slot table
   logic [SLOTS-1:0]        armed_ff, armed_in;
   logic [TIME_BITS-1:0]    slot_time_ff [SLOTS];
   logic [TIME_BITS-1:0]    slot_time_in [SLOTS];
   logic [ORDER_BITS-1:0]   slot_order_ff [SLOTS];
   logic [ORDER_BITS-1:0]   slot_order_in [SLOTS];
   logic [INDEX_BITS-1:0]   rank_ff [SLOTS];
   logic [INDEX_BITS-1:0]   rank_in [SLOTS];
   logic [ORDER_BITS-1:0]   order_counter_ff, order_counter_in;
   logic [TIME_BITS-1:0]    earliest_ff, earliest_in;

   // Search unit
   logic [INDEX_BITS-1:0]   idx_ff, idx_in;
   logic                    best_found_ff, best_found_in;
   logic [INDEX_BITS-1:0]   best_id_ff, best_id_in;
   logic [TIME_BITS-1:0]    best_time_ff, best_time_in;
   logic [ORDER_BITS-1:0]   best_order_ff, best_order_in;

   // Tick expiry tracking
   logic                    pend_ff, pend_in;
   logic [INDEX_BITS-1:0]   pend_id_ff, pend_id_in;
   logic [COUNT_BITS-1:0]   exp_count_ff, exp_count_in;

   // Result register
   logic                    rsp_strobe_ff;
   logic                    rsp_valid_ff;
   logic [ID_BITS-1:0]      rsp_id_ff;
   logic [TIME_BITS-1:0]    rsp_next_ff;
   logic                    rsp_status_ff;
   logic                    rsp_last_ff;

   logic [INDEX_BITS-1:0]   slot_sel;
   logic [TIME_BITS-1:0]    cand_time;
   logic [ORDER_BITS-1:0]   cand_order;
   logic                    cand_before;
   logic [TIME_BITS-1:0]    search_time;

   assign slot_sel    = INDEX_BITS'(req_id_ff);
   assign cand_time   = slot_time_ff[idx_ff];
   assign cand_order  = slot_order_ff[idx_ff];
   assign cand_before = (cand_time < best_time_ff) ||
                        ((cand_time == best_time_ff) && (cand_order < best_order_ff));
   assign search_time = best_found_ff ? best_time_ff : TIME_NONE;

   // Status toward the controller
   always_comb begin
      status.op          = req_op_ff;
      status.id_in_range = ({1'b0, req_id_ff} < (ID_BITS + 1)'(SLOTS));
      status.id_armed    = armed_ff[slot_sel];
      status.order_top   = (order_counter_ff == ORDER_TOP);
      status.idx_last    = (idx_ff == INDEX_BITS'(SLOTS - 1));
      status.pending     = pend_ff;
      status.due         = best_found_ff && (best_time_ff <= req_now_ff);
      status.count_full  = (exp_count_ff == COUNT_BITS'(RESULT_LIMIT));
   end

   // Next state of the slot table and counters
   always_comb begin
      armed_in         = armed_ff;
      slot_time_in     = slot_time_ff;
      slot_order_in    = slot_order_ff;
      rank_in          = rank_ff;
      order_counter_in = order_counter_ff;
      earliest_in      = earliest_ff;

      if (cmd.arm_write) begin
         armed_in[slot_sel]      = 1'b1;
         slot_time_in[slot_sel]  = req_expire_ff;
         slot_order_in[slot_sel] = order_counter_ff;
         order_counter_in        = order_counter_ff + 1'b1;
      end
      if (cmd.disarm) begin
         armed_in[slot_sel] = 1'b0;
      end
      if (cmd.expire) begin
         armed_in[best_id_ff] = 1'b0;
      end

      // Rank every slot against the one under the index
      if (cmd.rank_clear) begin
         order_counter_in = '0;
         for (int i = 0; i < SLOTS; i++) begin
            rank_in[i] = '0;
         end
      end else if (cmd.rank_step) begin
         if (armed_ff[idx_ff]) begin
            order_counter_in = order_counter_ff + 1'b1;
         end
         for (int i = 0; i < SLOTS; i++) begin
            if (armed_ff[idx_ff] && (cand_order < slot_order_ff[i])) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end

      // Renumber armed slots by rank
      if (cmd.rank_apply) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (armed_ff[i]) begin
               slot_order_in[i] = ORDER_BITS'(rank_ff[i]);
            end
         end
      end

      if (cmd.load_earliest) begin
         earliest_in = search_time;
      end
   end

   // Next state of the search unit and expiry tracking
   always_comb begin
      idx_in        = idx_ff;
      best_found_in = best_found_ff;
      best_id_in    = best_id_ff;
      best_time_in  = best_time_ff;
      best_order_in = best_order_ff;
      pend_in       = pend_ff;
      pend_id_in    = pend_id_ff;
      exp_count_in  = exp_count_ff;

      if (cmd.scan_clear || cmd.rank_clear) begin
         idx_in = '0;
      end else if (cmd.scan_step || cmd.rank_step) begin
         idx_in = idx_ff + 1'b1;
      end

      if (cmd.scan_clear) begin
         best_found_in = 1'b0;
      end else if (cmd.scan_step && armed_ff[idx_ff] && (!best_found_ff || cand_before)) begin
         best_found_in = 1'b1;
         best_id_in    = idx_ff;
         best_time_in  = cand_time;
         best_order_in = cand_order;
      end

      if (cmd.accept) begin
         pend_in      = 1'b0;
         exp_count_in = '0;
      end else if (cmd.expire) begin
         pend_in      = 1'b1;
         pend_id_in   = best_id_ff;
         exp_count_in = exp_count_ff + 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff         <= '0;
         order_counter_ff <= '0;
         earliest_ff      <= TIME_NONE;
         idx_ff           <= '0;
         best_found_ff    <= 1'b0;
         pend_ff          <= 1'b0;
         exp_count_ff     <= '0;
         rsp_strobe_ff    <= 1'b0;
      end else begin
         armed_ff         <= armed_in;
         order_counter_ff <= order_counter_in;
         earliest_ff      <= earliest_in;
         idx_ff           <= idx_in;
         best_found_ff    <= best_found_in;
         pend_ff          <= pend_in;
         exp_count_ff     <= exp_count_in;
         rsp_strobe_ff    <= cmd.emit;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      slot_time_ff  <= slot_time_in;
      slot_order_ff <= slot_order_in;
      rank_ff       <= rank_in;
      best_id_ff    <= best_id_in;
      best_time_ff  <= best_time_in;
      best_order_ff <= best_order_in;
      pend_id_ff    <= pend_id_in;
      if (cmd.accept) begin
         req_op_ff     <= op_type'(req_operation);
         req_id_ff     <= req_timer_id;
         req_expire_ff <= req_expire_time;
         req_now_ff    <= req_now_time;
      end
      if (cmd.emit) begin
         rsp_valid_ff  <= cmd.emit_valid;
         rsp_id_ff     <= cmd.emit_valid ? ID_BITS'(pend_id_ff) : '0;
         rsp_next_ff   <= earliest_in;
         rsp_status_ff <= cmd.emit_status;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_expired_valid = rsp_valid_ff;
   assign rsp_expired_id    = rsp_id_ff;
   assign rsp_next_expire   = rsp_next_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

   `EDTQ_ASSERT(a_count_bound, clock, reset, exp_count_ff <= COUNT_BITS'(RESULT_LIMIT), "expiry count passed the result limit")
   `EDTQ_ASSERT(a_expire_clears, clock, reset, cmd.expire |=> !armed_ff[pend_id_ff], "expired slot still armed")

endmodule

// ===== rtl/edtq_ctrl.sv =====
// Controller state machine of the timer queue: sequences dispatch, compaction, search and results.
// Depends on edtq_pkg; commands edtq_datapath through cmd_type and reads dp_status_type.
`timescale 1ns / 1ps

module edtq_ctrl
   import edtq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output cmd_type       cmd
);

`include "assert_macros.svh"

   state_type state_ff, state_in;
   logic      more_due;

   assign more_due = status.due && !status.count_full;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            unique case (status.op)
               OP_ARM: begin
                  if (!status.id_in_range || status.id_armed) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = status.id_in_range;
                     cmd.emit_last   = 1'b1;
                     state_in        = ST_IDLE;
                  end else if (status.order_top) begin
                     cmd.rank_clear = 1'b1;
                     state_in       = ST_COMPACT;
                  end else begin
                     state_in = ST_WRITE;
                  end
               end
               OP_CANCEL: begin
                  if (status.id_in_range && status.id_armed) begin
                     cmd.disarm     = 1'b1;
                     cmd.scan_clear = 1'b1;
                     state_in       = ST_SEARCH;
                  end else begin
                     cmd.emit      = 1'b1;
                     cmd.emit_last = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
               OP_TICK: begin
                  cmd.scan_clear = 1'b1;
                  state_in       = ST_SEARCH;
               end
               OP_NONE: begin
                  cmd.emit      = 1'b1;
                  cmd.emit_last = 1'b1;
                  state_in      = ST_IDLE;
               end
            endcase
         end

         // Rank the armed slots, one reference slot a cycle
         ST_COMPACT: begin
            cmd.rank_step = 1'b1;
            if (status.idx_last) begin
               state_in = ST_APPLY;
            end
         end

         ST_APPLY: begin
            cmd.rank_apply = 1'b1;
            state_in       = ST_WRITE;
         end

         ST_WRITE: begin
            cmd.arm_write  = 1'b1;
            cmd.scan_clear = 1'b1;
            state_in       = ST_SEARCH;
         end

         // Walk all slots for the earliest armed one
         ST_SEARCH: begin
            cmd.scan_step = 1'b1;
            if (status.idx_last) begin
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            cmd.load_earliest = 1'b1;
            if (status.op != OP_TICK) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end else if (status.pending) begin
               // Report the slot expired before this search
               cmd.emit       = 1'b1;
               cmd.emit_valid = 1'b1;
               cmd.emit_last  = !more_due;
               if (more_due) begin
                  cmd.expire     = 1'b1;
                  cmd.scan_clear = 1'b1;
                  state_in       = ST_SEARCH;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (status.due) begin
               cmd.expire     = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in       = ST_SEARCH;
            end else begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `EDTQ_ASSERT(a_last_to_idle, clock, reset, (cmd.emit && cmd.emit_last) |=> (state_ff == ST_IDLE), "final result did not end the command")
   `EDTQ_ASSERT(a_more_to_search, clock, reset, (cmd.emit && !cmd.emit_last) |=> (state_ff == ST_SEARCH), "non-final result not followed by a search")
   `EDTQ_ASSERT_NEVER(a_expire_no_slot, clock, reset, cmd.expire && !status.due, "expiry without a due slot")

endmodule

// ===== rtl/earliest_deadline_timer_queue_unit.sv =====
// A rejected arm, an idle cancel or an unused operation reports straight from dispatch.
// A cancel of an armed slot, a tick and an arm run a search first, an arm may compact the
// insertion counter before that, and a tick runs one more search per expired slot.
// Each search walks the 16 slot registers one slot a cycle.
// busy falls in the cycle of the final strobe, so a new command can follow at once.
// Synchronous active-high reset disarms all slots and clears the controller; no clearing pass.
`timescale 1ns / 1ps

module earliest_deadline_timer_queue_unit
   import edtq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_operation,
   input  logic [ID_BITS-1:0]    req_timer_id,
   input  logic [TIME_BITS-1:0]  req_expire_time,
   input  logic [TIME_BITS-1:0]  req_now_time,
   output logic                  rsp_strobe,
   output logic                  rsp_expired_valid,
   output logic [ID_BITS-1:0]    rsp_expired_id,
   output logic [TIME_BITS-1:0]  rsp_next_expire,
   output logic                  rsp_status,
   output logic                  rsp_last
);

   cmd_type       cmd;
   dp_status_type dp_status;

   // Sequencer
   edtq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (dp_status),
      .cmd    (cmd)
   );

   // Slot table and result register
   edtq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_timer_id      (req_timer_id),
      .req_expire_time   (req_expire_time),
      .req_now_time      (req_now_time),
      .cmd               (cmd),
      .status            (dp_status),
      .rsp_strobe        (rsp_strobe),
      .rsp_expired_valid (rsp_expired_valid),
      .rsp_expired_id    (rsp_expired_id),
      .rsp_next_expire   (rsp_next_expire),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for earliest_deadline_timer_queue_unit: directed table, then random
// arm/cancel/tick traffic checked against a behavioral timer table. Depends on edtq_pkg and the RTL.

module tb_top
   import edtq_pkg::*;
();

   localparam int CLOCK_HIGH      = 4;
   localparam int CLOCK_LOW       = 4;
   localparam int RESET_CYCLES    = 4;
   localparam int RANDOM_COMMANDS = 150;
   localparam int BURST_SPACING   = 50;
   localparam int MODE_SPACING    = 25;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int NUM_PLAN        = 21;

   localparam logic [TIME_BITS-1:0] TIME_ALT_HI = 48'hAAAA_AAAA_AAAA;
   localparam logic [TIME_BITS-1:0] TIME_ALT_LO = 48'h5555_5555_5555;
   localparam logic [TIME_BITS-1:0] TIME_MID    = 48'h6000_0000_0000;

   typedef struct packed {
      logic                 expired_valid;
      logic [ID_BITS-1:0]   expired_id;
      logic [TIME_BITS-1:0] next_expire;
      logic                 status;
      logic                 last;
   } timer_report_type;

   typedef struct packed {
      op_type               op;
      logic [ID_BITS-1:0]   timer_id;
      logic [TIME_BITS-1:0] expire_time;
      logic [TIME_BITS-1:0] now_time;
      logic                 preset;   // report below is written out by hand
      timer_report_type     report;
   } timer_command_type;

   // Clock and block ports; every input starts at a known value
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [1:0]           req_operation = '0;
   logic [ID_BITS-1:0]   req_timer_id = '0;
   logic [TIME_BITS-1:0] req_expire_time = '0;
   logic [TIME_BITS-1:0] req_now_time = '0;
   logic                 rsp_strobe;
   logic                 rsp_expired_valid;
   logic [ID_BITS-1:0]   rsp_expired_id;
   logic [TIME_BITS-1:0] rsp_next_expire;
   logic                 rsp_status;
   logic                 rsp_last;

   // Shadow timer table
   logic                  shadow_armed [SLOTS];
   logic [TIME_BITS-1:0]  shadow_time  [SLOTS];
   logic [ORDER_BITS-1:0] shadow_seq   [SLOTS];
   logic [ORDER_BITS-1:0] seq_counter;
   logic [TIME_BITS-1:0]  shadow_earliest;
   timer_report_type      awaited_reports [$];

   logic [TIME_BITS-1:0]  wall_clock_us;
   logic                  steady_sender;
   int                    error_count = 0;
   int                    cycle_count = 0;
   int                    commands_sent = 0;
   int                    arms_sent = 0;
   int                    cancels_sent = 0;
   int                    ticks_sent = 0;
   int                    unused_sent = 0;
   int                    reports_checked = 0;
   int                    expirations_total = 0;
   int                    widest_tick = 0;

   // Directed table: extremes, rejection, ties, empty and unused operations
   timer_command_type plan [0:NUM_PLAN-1] = '{
      '{OP_TICK,   4'd0,  48'd0,       48'd0,       1'b1, '{1'b0, 4'd0, TIME_NONE, 1'b0, 1'b1}},
      '{OP_NONE,   4'd7,  TIME_NONE,   TIME_NONE,   1'b1, '{1'b0, 4'd0, TIME_NONE, 1'b0, 1'b1}},
      '{OP_CANCEL, 4'd5,  48'd0,       48'd0,       1'b1, '{1'b0, 4'd0, TIME_NONE, 1'b0, 1'b1}},
      '{OP_ARM,    4'd0,  48'd0,       TIME_NONE,   1'b1, '{1'b0, 4'd0, 48'd0,     1'b0, 1'b1}},
      '{OP_ARM,    4'd0,  48'd100,     48'd0,       1'b1, '{1'b0, 4'd0, 48'd0,     1'b1, 1'b1}},
      '{OP_ARM,    4'd15, TIME_NONE,   48'd0,       1'b1, '{1'b0, 4'd0, 48'd0,     1'b0, 1'b1}},
      '{OP_TICK,   4'd0,  48'd0,       48'd0,       1'b0, '0},
      '{OP_TICK,   4'd15, TIME_NONE,   TIME_NONE,   1'b0, '0},
      '{OP_CANCEL, 4'd15, 48'd0,       48'd0,       1'b1, '{1'b0, 4'd0, TIME_NONE, 1'b0, 1'b1}},
      '{OP_ARM,    4'd3,  48'd50,      48'd0,       1'b1, '{1'b0, 4'd0, 48'd50,    1'b0, 1'b1}},
      '{OP_ARM,    4'd2,  48'd50,      48'd0,       1'b1, '{1'b0, 4'd0, 48'd50,    1'b0, 1'b1}},
      '{OP_ARM,    4'd9,  48'd20,      48'd0,       1'b1, '{1'b0, 4'd0, 48'd20,    1'b0, 1'b1}},
      '{OP_ARM,    4'd12, TIME_ALT_HI, TIME_ALT_LO, 1'b1, '{1'b0, 4'd0, 48'd20,    1'b0, 1'b1}},
      '{OP_ARM,    4'd7,  TIME_ALT_LO, TIME_ALT_HI, 1'b0, '0},
      '{OP_CANCEL, 4'd9,  TIME_ALT_HI, TIME_ALT_LO, 1'b0, '0},
      '{OP_NONE,   4'd15, TIME_NONE,   TIME_NONE,   1'b0, '0},
      '{OP_TICK,   4'd10, TIME_ALT_LO, 48'd49,      1'b0, '0},
      '{OP_TICK,   4'd5,  TIME_ALT_HI, 48'd50,      1'b0, '0},
      '{OP_ARM,    4'd3,  48'd10,      48'd0,       1'b0, '0},
      '{OP_TICK,   4'd0,  48'd0,       TIME_MID,    1'b0, '0},
      '{OP_CANCEL, 4'd12, 48'd0,       48'd0,       1'b1, '{1'b0, 4'd0, TIME_NONE, 1'b0, 1'b1}}
   };

   earliest_deadline_timer_queue_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_timer_id      (req_timer_id),
      .req_expire_time   (req_expire_time),
      .req_now_time      (req_now_time),
      .rsp_strobe        (rsp_strobe),
      .rsp_expired_valid (rsp_expired_valid),
      .rsp_expired_id    (rsp_expired_id),
      .rsp_next_expire   (rsp_next_expire),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   // Free-running clock
   always begin
      #(CLOCK_LOW) clock = 1'b1;
      #(CLOCK_HIGH) clock = 1'b0;
   end

   // Armed slot that expires first: earliest time, then earliest insertion; SLOTS if none
   function automatic int earliest_slot();
      int best;
      int i;
      best = SLOTS;
      for (i = 0; i < SLOTS; i++) begin
         if (shadow_armed[i] && (best == SLOTS || shadow_time[i] < shadow_time[best] ||
             (shadow_time[i] == shadow_time[best] && shadow_seq[i] < shadow_seq[best])))
            best = i;
      end
      return best;
   endfunction

   function automatic void refresh_earliest_time();
      int f;
      f = earliest_slot();
      shadow_earliest = (f == SLOTS) ? TIME_NONE : shadow_time[f];
   endfunction

   // Renumber armed slots by insertion rank so the counter can restart low
   function automatic void renumber_sequence();
      logic [ORDER_BITS-1:0] rank [SLOTS];
      logic [ORDER_BITS-1:0] count;
      int i;
      int j;
      count = '0;
      for (i = 0; i < SLOTS; i++) begin
         rank[i] = '0;
         if (shadow_armed[i]) begin
            for (j = 0; j < SLOTS; j++) begin
               if (shadow_armed[j] && shadow_seq[j] < shadow_seq[i])
                  rank[i] = rank[i] + 1'b1;
            end
            count = count + 1'b1;
         end
      end
      for (i = 0; i < SLOTS; i++) begin
         if (shadow_armed[i])
            shadow_seq[i] = rank[i];
      end
      seq_counter = count;
   endfunction

   // Apply one command to the shadow table; queue its reports when record is set
   function automatic void timer_table_step(input timer_command_type c, input bit record);
      timer_report_type r;
      int               due_total;
      int               n;
      int               f;
      int               i;
      r = '0;
      r.last = 1'b1;
      case (c.op)
         OP_ARM: begin
            if (shadow_armed[c.timer_id]) begin
               r.status = 1'b1;
            end else begin
               if (seq_counter == ORDER_TOP)
                  renumber_sequence();
               shadow_armed[c.timer_id] = 1'b1;
               shadow_time[c.timer_id]  = c.expire_time;
               shadow_seq[c.timer_id]   = seq_counter;
               seq_counter = seq_counter + 1'b1;
               refresh_earliest_time();
            end
         end
         OP_CANCEL: begin
            if (shadow_armed[c.timer_id]) begin
               shadow_armed[c.timer_id] = 1'b0;
               refresh_earliest_time();
            end
         end
         OP_TICK: begin
            due_total = 0;
            for (i = 0; i < SLOTS; i++) begin
               if (shadow_armed[i] && shadow_time[i] <= c.now_time)
                  due_total++;
            end
            if (due_total > RESULT_LIMIT)
               due_total = RESULT_LIMIT;
            // expire due slots in deadline order, one report each
            for (n = 0; n < due_total; n++) begin
               f = earliest_slot();
               shadow_armed[f] = 1'b0;
               refresh_earliest_time();
               r.expired_valid = 1'b1;
               r.expired_id    = f[ID_BITS-1:0];
               r.next_expire   = shadow_earliest;
               r.last          = (n == due_total - 1);
               if (record)
                  awaited_reports.push_back(r);
            end
            expirations_total += due_total;
            if (due_total > widest_tick)
               widest_tick = due_total;
            if (due_total > 0)
               return;
         end
         default: ;
      endcase
      r.next_expire = shadow_earliest;
      if (record)
         awaited_reports.push_back(r);
   endfunction

   // Present one command, hold until the transfer, predict, then idle a random gap
   task automatic issue_command(input timer_command_type c);
      int gap;
      int roll;
      req_operation   <= c.op;
      req_timer_id    <= c.timer_id;
      req_expire_time <= c.expire_time;
      req_now_time    <= c.now_time;
      start           <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      timer_table_step(c, !c.preset);
      if (c.preset)
         awaited_reports.push_back(c.report);
      commands_sent++;
      case (c.op)
         OP_ARM:    arms_sent++;
         OP_CANCEL: cancels_sent++;
         OP_TICK:   ticks_sent++;
         default:   unused_sent++;
      endcase
      roll = $urandom_range(0, 99);
      if (steady_sender || roll < 55)
         gap = 0;
      else if (roll < 88)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(8, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Mostly well-formed traffic around a running time base, with some noise
   function automatic timer_command_type random_command();
      timer_command_type c;
      logic [63:0]       noise_a;
      logic [63:0]       noise_b;
      int                pick;
      int                k;
      int                slot;
      noise_a = {$urandom, $urandom};
      noise_b = {$urandom, $urandom};
      c = '0;
      c.timer_id    = ID_BITS'($urandom_range(0, SLOTS - 1));
      c.expire_time = noise_a[TIME_BITS-1:0];
      c.now_time    = noise_b[TIME_BITS-1:0];
      slot = int'(c.timer_id);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         // arm an idle slot, close to the time base so ties happen
         for (k = 0; k < SLOTS && shadow_armed[slot]; k++)
            slot = (slot + 1) % SLOTS;
         if (shadow_armed[slot]) begin
            c.op = OP_TICK;
            c.now_time = wall_clock_us + 48'd200;
         end else begin
            c.op = OP_ARM;
            c.timer_id = ID_BITS'(slot);
            k = $urandom_range(0, 9);
            if (k == 1)
               c.expire_time = wall_clock_us;
            else if (k > 1)
               c.expire_time = wall_clock_us + 48'(10 * $urandom_range(0, 15));
         end
      end else if (pick < 55) begin
         // cancel an armed slot when there is one
         for (k = 0; k < SLOTS && !shadow_armed[slot]; k++)
            slot = (slot + 1) % SLOTS;
         c.op = OP_CANCEL;
         c.timer_id = ID_BITS'(slot);
      end else if (pick < 80) begin
         // advance the time base and tick
         wall_clock_us = wall_clock_us + 48'($urandom_range(0, 150));
         c.op = OP_TICK;
         c.now_time = wall_clock_us;
      end else if (pick < 88) begin
         c.op = OP_ARM;
      end else if (pick < 93) begin
         c.op = OP_CANCEL;
      end else if (pick < 97) begin
         c.op = OP_NONE;
      end else begin
         c.op = OP_TICK;
      end
      return c;
   endfunction

   // Check each strobed report against the oldest expectation
   always @(posedge clock) begin
      timer_report_type want;
      if (!reset && $isunknown(rsp_strobe)) begin
         $display("%0t ns: rsp_strobe unknown", $time);
         error_count++;
      end else if (!reset && rsp_strobe) begin
         if (awaited_reports.size() == 0) begin
            $display("%0t ns: unexpected report expected none got id %0d next %h", $time,
                     rsp_expired_id, rsp_next_expire);
            error_count++;
         end else begin
            want = awaited_reports.pop_front();
            reports_checked++;
            if (rsp_expired_valid !== want.expired_valid) begin
               $display("%0t ns: expired_valid expected %0b got %0b", $time,
                        want.expired_valid, rsp_expired_valid);
               error_count++;
            end
            if (rsp_expired_id !== want.expired_id) begin
               $display("%0t ns: expired_id expected %0d got %0d", $time,
                        want.expired_id, rsp_expired_id);
               error_count++;
            end
            if (rsp_next_expire !== want.next_expire) begin
               $display("%0t ns: next_expire expected %h got %h", $time,
                        want.next_expire, rsp_next_expire);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t ns: status expected %0b got %0b", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t ns: last expected %0b got %0b", $time, want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Reset, directed table, random traffic, drain
   initial begin
      timer_command_type cmd;
      int                row;
      int                slot;
      int                next_burst;
      int                next_mode_change;
      logic [63:0]       noise;
      for (slot = 0; slot < SLOTS; slot++) begin
         shadow_armed[slot] = 1'b0;
         shadow_time[slot]  = '0;
         shadow_seq[slot]   = '0;
      end
      seq_counter     = '0;
      shadow_earliest = TIME_NONE;
      wall_clock_us   = 48'd1000;
      steady_sender   = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      for (row = 0; row < NUM_PLAN; row++)
         issue_command(plan[row]);

      // random traffic, with a full-table expiry burst at intervals
      next_burst       = commands_sent + 20;
      next_mode_change = commands_sent + MODE_SPACING;
      while (commands_sent < NUM_PLAN + RANDOM_COMMANDS) begin
         if (commands_sent >= next_mode_change) begin
            steady_sender    = ($urandom_range(0, 3) == 0);
            next_mode_change = commands_sent + MODE_SPACING;
         end
         if (commands_sent >= next_burst) begin
            next_burst = commands_sent + BURST_SPACING;
            for (slot = 0; slot < SLOTS; slot++) begin
               if (!shadow_armed[slot]) begin
                  noise = {$urandom, $urandom};
                  cmd = '0;
                  cmd.op = OP_ARM;
                  cmd.timer_id = ID_BITS'(slot);
                  cmd.expire_time = wall_clock_us + 48'(5 * $urandom_range(0, 4));
                  cmd.now_time = noise[TIME_BITS-1:0];
                  issue_command(cmd);
               end
            end
            cmd = '0;
            cmd.op = OP_TICK;
            cmd.timer_id = ID_BITS'($urandom_range(0, SLOTS - 1));
            cmd.now_time = TIME_NONE;
            issue_command(cmd);
         end else begin
            issue_command(random_command());
         end
      end
      start <= 1'b0;

      // drain outstanding reports, then watch for strays
      while (awaited_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d commands: %0d arm, %0d cancel, %0d tick, %0d unused op",
               commands_sent, arms_sent, cancels_sent, ticks_sent, unused_sent);
      $display("Checked %0d reports; %0d timers expired, up to %0d in one tick",
               reports_checked, expirations_total, widest_tick);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/edtq_pkg.sv
rtl/edtq_datapath.sv
rtl/edtq_ctrl.sv
rtl/earliest_deadline_timer_queue_unit.sv
sim/tb_top.sv
